// ===== rtl/core/knn_pkg.sv =====
// Package for the k-nearest-neighbor vote classifier.
// Shared constants, mode codes and sequencer state type.
// No dependencies; imported by every module of the block.
package knn_pkg;

  // Fixed field widths
  localparam int SAMPLE_BITS  = 16;
  localparam int CLASS_COUNT  = 16;
  localparam int CLS_W        = 4;
  localparam int VOTE_W       = 7;
  localparam int ACC_W        = 40;
  localparam int SQ_W         = 2 * (SAMPLE_BITS + 1);
  localparam int WORD_W       = 2 * SAMPLE_BITS;

  // Default sizing
  localparam int DEF_MAX_REFERENCES = 64;
  localparam int DEF_VECTOR_LENGTH  = 64;

  // Register reset and reject threshold (votes * 5 <= k * 4)
  localparam logic [VOTE_W-1:0] K_RESET = 7'd5;
  localparam int REJ_VOTE_MUL = 5;
  localparam int REJ_K_MUL    = 4;

  localparam logic [ACC_W-1:0] ACC_MAX = {ACC_W{1'b1}};

  // Command codes on mode
  typedef enum logic [1:0] {
    MODE_LOAD  = 2'd0,
    MODE_QUERY = 2'd1,
    MODE_CLEAR = 2'd2,
    MODE_NONE  = 2'd3
  } mode_t;

  // Sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_Q_RD,
    S_Q_MRE,
    S_Q_MIM,
    S_Q_ACC,
    S_D_INIT,
    S_D_SCAN,
    S_D_PICK,
    S_D_VOTE,
    S_D_TALLY,
    S_D_OUT
  } state_t;

endpackage

// ===== rtl/core/knn_sq_unit.sv =====
// Shared squared-difference unit: |a - b|^2 of one signed component.
// Depends on knn_pkg for sample and product widths.
module knn_sq_unit (
  input  logic signed [knn_pkg::SAMPLE_BITS-1:0] a,
  input  logic signed [knn_pkg::SAMPLE_BITS-1:0] b,
  output logic        [knn_pkg::SQ_W-1:0]        sq
);
  import knn_pkg::*;

  logic signed [SAMPLE_BITS:0] diff;
  logic        [SAMPLE_BITS:0] mag;

  // difference, magnitude, then one multiply
  always_comb begin
    diff = (SAMPLE_BITS+1)'(a) - (SAMPLE_BITS+1)'(b);
    mag  = diff[SAMPLE_BITS] ? (SAMPLE_BITS+1)'(-diff) : (SAMPLE_BITS+1)'(diff);
    sq   = SQ_W'(mag) * SQ_W'(mag);
  end

endmodule

// ===== rtl/core/knn_vote_classifier_top.sv =====
// Top level of the k-nearest-neighbor vote classifier.
// Depends on knn_pkg and knn_sq_unit.
//
// Usage: a beat is taken on start when busy is low. mode selects a reference
// element load, a query element or a table clear. Loads and clears finish in
// the accepting cycle and never raise busy. A query element walks every
// stored reference with one shared squaring unit, stepping through read,
// real square, imaginary square and accumulate for each reference (the first
// element of a query also zeroes the remaining slots); a later element
// that finds the table empty only advances the position. The last query
// element then runs the selection: m scans of the distance memory, m =
// max(k,3) clamped to the reference count, each followed by a pick and a
// vote, then a tally of the votes of all CLASS_COUNT classes and an output
// state. The result appears on the result ports for one cycle with done
// high; the receiver cannot stall, so nothing waits on it.
// The k register is written on cfg_valid & cfg_ready, ready only when idle.
// Reset (rst, synchronous) empties the table, zeroes the element positions
// and sets k to 5; the memories are not cleared and need no clearing pass.
module knn_vote_classifier_top #(
  parameter int MAX_REFERENCES = knn_pkg::DEF_MAX_REFERENCES,
  parameter int VECTOR_LENGTH  = knn_pkg::DEF_VECTOR_LENGTH
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic [1:0]                        mode,
  input  logic signed [knn_pkg::SAMPLE_BITS-1:0] real_part,
  input  logic signed [knn_pkg::SAMPLE_BITS-1:0] imag_part,
  input  logic [knn_pkg::CLS_W-1:0]         class_label,
  input  logic                              last_element,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [knn_pkg::VOTE_W-1:0]        cfg_data,
  output logic                              done,
  output logic [knn_pkg::CLS_W-1:0]         predicted_class,
  output logic                              rejected,
  output logic [knn_pkg::VOTE_W-1:0]        vote_count,
  output logic                              table_empty
);
  import knn_pkg::*;

  localparam int DEPTH   = MAX_REFERENCES * VECTOR_LENGTH;
  localparam int SADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int RIDX_W  = $clog2(MAX_REFERENCES);
  localparam int CNT_W   = $clog2(MAX_REFERENCES + 1);
  localparam int POS_W   = $clog2(VECTOR_LENGTH + 1);
  localparam int KW      = (CNT_W > VOTE_W) ? CNT_W : VOTE_W;
  localparam int CMP_W   = VOTE_W + 3;

  // Memories
  logic [WORD_W-1:0] store_mem [DEPTH];
  logic [ACC_W-1:0]  dist_mem  [MAX_REFERENCES];
  logic [CLS_W-1:0]  cls_mem   [MAX_REFERENCES];

  state_t state, state_next;

  logic [VOTE_W-1:0]  ncount;
  logic [CNT_W-1:0]   total;
  logic [POS_W-1:0]   load_pos;
  logic [POS_W-1:0]   qpos;
  logic [SADDR_W-1:0] load_base;
  logic [SADDR_W-1:0] qbase;

  // query element working registers
  logic signed [SAMPLE_BITS-1:0] q_re, q_im;
  logic               q_last, q_first;
  logic [CNT_W-1:0]   ridx, qbound;
  logic [WORD_W-1:0]  store_q;
  logic [ACC_W-1:0]   dist_q;
  logic [SQ_W-1:0]    sq_re;
  logic [SQ_W:0]      dsum;

  // selection registers
  logic [CNT_W-1:0]   sa;
  logic               rv;
  logic [RIDX_W-1:0]  rv_idx;
  logic               found;
  logic [RIDX_W-1:0]  best_idx;
  logic [ACC_W-1:0]   best_dist;
  logic [MAX_REFERENCES-1:0] taken;
  logic [CLS_W-1:0]   cls_q;
  logic [VOTE_W-1:0]  k_eff, m_cnt, p;
  logic [CLS_W-1:0]   n0, n1, n2;
  logic [VOTE_W-1:0]  votes [CLASS_COUNT];
  logic [CLS_W-1:0]   tc, best_class;
  logic [VOTE_W-1:0]  best_votes;
  logic               empty_flag;

  // shared unit operands
  logic signed [SAMPLE_BITS-1:0] op_a, op_b;
  logic [SQ_W-1:0]    sq;

  logic               accept;
  logic [RIDX_W-1:0]  dist_ra;
  logic               dist_we;
  logic [ACC_W-1:0]   dist_wd;
  logic [ACC_W+1:0]   acc_sum;
  logic               last_ref;
  logic               scan_done;

  knn_sq_unit u_sq (
    .a  (op_a),
    .b  (op_b),
    .sq (sq)
  );

  assign accept = start && !busy;

  // Operand select for the shared squaring unit
  always_comb begin
    if (state == S_Q_MIM) begin
      op_a = store_q[SAMPLE_BITS-1:0];
      op_b = q_im;
    end else begin
      op_a = store_q[WORD_W-1:SAMPLE_BITS];
      op_b = q_re;
    end
  end

  // Accumulate sum (saturated when written back) and loop-end flags
  always_comb begin
    acc_sum = q_first ? (ACC_W+2)'(dsum) : (ACC_W+2)'(dist_q) + (ACC_W+2)'(dsum);
    last_ref  = (ridx + CNT_W'(1)) == qbound;
    scan_done = (sa == total) && !rv;
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept && mode == MODE_QUERY) begin
          if (qpos < POS_W'(VECTOR_LENGTH) && (qpos == '0 || total != '0)) begin
            state_next = S_Q_RD;
          end else if (last_element) begin
            state_next = S_D_INIT;
          end
        end
      end
      S_Q_RD: begin
        if (ridx >= total) begin
          if (last_ref) state_next = q_last ? S_D_INIT : S_IDLE;
        end else begin
          state_next = S_Q_MRE;
        end
      end
      S_Q_MRE: state_next = S_Q_MIM;
      S_Q_MIM: state_next = S_Q_ACC;
      S_Q_ACC: begin
        if (last_ref) state_next = q_last ? S_D_INIT : S_IDLE;
        else          state_next = S_Q_RD;
      end
      S_D_INIT:  state_next = (total == '0) ? S_D_OUT : S_D_SCAN;
      S_D_SCAN:  if (scan_done) state_next = S_D_PICK;
      S_D_PICK:  state_next = S_D_VOTE;
      S_D_VOTE:  state_next = ((p + VOTE_W'(1)) == m_cnt) ? S_D_TALLY : S_D_SCAN;
      S_D_TALLY: if (tc == CLS_W'(CLASS_COUNT - 1)) state_next = S_D_OUT;
      S_D_OUT:   state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  // Outputs and memory controls
  always_comb begin
    busy      = (state != S_IDLE);
    cfg_ready = (state == S_IDLE);
    done      = (state == S_D_OUT);
    predicted_class = best_class;
    vote_count      = best_votes;
    table_empty     = empty_flag;
    rejected = empty_flag ||
               (((CMP_W'(best_votes) * CMP_W'(REJ_VOTE_MUL)) <=
                 (CMP_W'(k_eff) * CMP_W'(REJ_K_MUL))) &&
                ((total < CNT_W'(3)) || (n0 != n1) || (n1 != n2)));
    dist_we = 1'b0;
    dist_wd = '0;
    if (state == S_Q_RD && ridx >= total) begin
      dist_we = 1'b1;
    end else if (state == S_Q_ACC) begin
      dist_we = 1'b1;
      dist_wd = (acc_sum > (ACC_W+2)'(ACC_MAX)) ? ACC_MAX : acc_sum[ACC_W-1:0];
    end
    dist_ra = (state == S_D_SCAN) ? sa[RIDX_W-1:0] : ridx[RIDX_W-1:0];
  end

  // Reference store
  always_ff @(posedge clk) begin
    if (accept && mode == MODE_LOAD && total < CNT_W'(MAX_REFERENCES) &&
        load_pos < POS_W'(VECTOR_LENGTH)) begin
      store_mem[load_base + SADDR_W'(load_pos)] <= {real_part, imag_part};
    end
    store_q <= store_mem[qbase];
  end

  // Class labels; labels above the class range clamp to the top class
  always_ff @(posedge clk) begin
    if (accept && mode == MODE_LOAD && total < CNT_W'(MAX_REFERENCES) && last_element) begin
      cls_mem[total[RIDX_W-1:0]] <= (32'(class_label) > CLASS_COUNT - 1) ?
                                    CLS_W'(CLASS_COUNT - 1) : class_label;
    end
    cls_q <= cls_mem[best_idx];
  end

  // Distance accumulators
  always_ff @(posedge clk) begin
    if (dist_we) dist_mem[ridx[RIDX_W-1:0]] <= dist_wd;
    dist_q <= dist_mem[dist_ra];
  end

  // State and control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      ncount    <= K_RESET;
      total     <= '0;
      load_pos  <= '0;
      load_base <= '0;
      qpos      <= '0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) ncount <= cfg_data;
      if (accept) begin
        unique case (mode)
          MODE_LOAD: begin
            if (total < CNT_W'(MAX_REFERENCES)) begin
              if (last_element) begin
                total     <= total + CNT_W'(1);
                load_pos  <= '0;
                load_base <= load_base + SADDR_W'(VECTOR_LENGTH);
              end else if (load_pos < POS_W'(VECTOR_LENGTH)) begin
                load_pos <= load_pos + POS_W'(1);
              end
            end
          end
          MODE_QUERY: begin
            if (last_element) qpos <= '0;
            else if (qpos < POS_W'(VECTOR_LENGTH)) qpos <= qpos + POS_W'(1);
          end
          MODE_CLEAR: begin
            total     <= '0;
            load_pos  <= '0;
            load_base <= '0;
          end
          MODE_NONE: ;
          default: ;
        endcase
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        q_re    <= real_part;
        q_im    <= imag_part;
        q_last  <= last_element;
        q_first <= (qpos == '0);
        ridx    <= '0;
        qbase   <= SADDR_W'(qpos);
        qbound  <= (qpos == '0) ? CNT_W'(MAX_REFERENCES) : total;
      end
      S_Q_RD: begin
        if (ridx >= total) ridx <= ridx + CNT_W'(1);
      end
      S_Q_MRE: sq_re <= sq;
      S_Q_MIM: dsum  <= (SQ_W+1)'(sq_re) + (SQ_W+1)'(sq);
      S_Q_ACC: begin
        ridx  <= ridx + CNT_W'(1);
        qbase <= qbase + SADDR_W'(VECTOR_LENGTH);
      end
      S_D_INIT: begin
        logic [KW-1:0] kc, mm;
        kc = (ncount == '0) ? KW'(1) : KW'(ncount);
        if (kc > KW'(total)) kc = KW'(total);
        mm = (kc < KW'(3)) ? KW'(3) : kc;
        if (mm > KW'(total)) mm = KW'(total);
        k_eff      <= VOTE_W'(kc);
        m_cnt      <= VOTE_W'(mm);
        p          <= '0;
        taken      <= '0;
        sa         <= '0;
        rv         <= 1'b0;
        found      <= 1'b0;
        best_class <= '0;
        best_votes <= '0;
        empty_flag <= (total == '0);
        for (int c = 0; c < CLASS_COUNT; c++) votes[c] <= '0;
      end
      S_D_SCAN: begin
        if (sa < total) sa <= sa + CNT_W'(1);
        rv     <= (sa < total);
        rv_idx <= sa[RIDX_W-1:0];
        // strict less-than keeps the lower slot on equal distance
        if (rv && !taken[rv_idx] && (!found || dist_q < best_dist)) begin
          found     <= 1'b1;
          best_idx  <= rv_idx;
          best_dist <= dist_q;
        end
      end
      S_D_PICK: taken[best_idx] <= 1'b1;
      S_D_VOTE: begin
        if (p == VOTE_W'(0)) n0 <= cls_q;
        if (p == VOTE_W'(1)) n1 <= cls_q;
        if (p == VOTE_W'(2)) n2 <= cls_q;
        for (int c = 0; c < CLASS_COUNT; c++) begin
          if (CLS_W'(c) == cls_q && p < k_eff) votes[c] <= votes[c] + VOTE_W'(1);
        end
        p     <= p + VOTE_W'(1);
        sa    <= '0;
        rv    <= 1'b0;
        found <= 1'b0;
        tc    <= '0;
      end
      S_D_TALLY: begin
        // votes shift down; the head is class tc, lowest class wins ties
        if (votes[0] > best_votes) begin
          best_votes <= votes[0];
          best_class <= tc;
        end
        for (int c = 0; c < CLASS_COUNT - 1; c++) votes[c] <= votes[c+1];
        votes[CLASS_COUNT-1] <= '0;
        tc <= tc + CLS_W'(1);
      end
      S_D_OUT: ;
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  // result strobe lasts a single cycle
  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("done held more than one cycle");
  // empty table always rejects with no votes
  a_empty_rej: assert property (@(posedge clk) disable iff (rst)
    (done && table_empty) |-> (rejected && vote_count == '0))
    else $error("empty table result malformed");
  // a non-empty table gives the winner at least one vote
  a_votes: assert property (@(posedge clk) disable iff (rst)
    (done && !table_empty) |-> (vote_count != '0))
    else $error("winner without votes");
  // loads and clears complete without raising busy
  a_load_fast: assert property (@(posedge clk) disable iff (rst)
    (accept && (mode == MODE_LOAD || mode == MODE_CLEAR)) |=> !busy)
    else $error("load beat left block busy");
`endif

endmodule

// ===== tb/knn_vote_classifier_top_test.sv =====
// Self-checking testbench for knn_vote_classifier_top: directed rows, then
// phases of labelled reference loads and queries, checked by a local predictor.
// Depends on knn_pkg and the classifier RTL only.
`timescale 1ns / 1ps

module knn_vote_classifier_top_test;
  import knn_pkg::*;

  localparam int REFS      = DEF_MAX_REFERENCES;
  localparam int VLEN      = DEF_VECTOR_LENGTH;
  localparam int ITEMS     = 1100;
  localparam int CALM_FROM = 950;
  localparam int WD_LIMIT  = 100000;

  typedef struct packed {
    logic [CLS_W-1:0]  cls;
    logic              rej;
    logic [VOTE_W-1:0] votes;
    logic              empty;
  } outcome_t;

  typedef struct packed {
    mode_t                   m;
    logic [SAMPLE_BITS-1:0]  re;
    logic [SAMPLE_BITS-1:0]  im;
    logic [CLS_W-1:0]        lab;
    logic                    last;
    logic                    typed;
    outcome_t                ex;
  } row_t;

  localparam outcome_t EMPTY_OUT = '{cls: '0, rej: 1'b1, votes: '0, empty: 1'b1};
  localparam outcome_t NO_OUT    = '0;

  logic clk, rst;
  logic start, busy;
  mode_t cmd_mode;
  logic signed [SAMPLE_BITS-1:0] real_part, imag_part;
  logic [CLS_W-1:0] class_label;
  logic last_element;
  logic cfg_valid, cfg_ready;
  logic [VOTE_W-1:0] cfg_data;
  logic done, rejected, table_empty;
  logic [CLS_W-1:0] predicted_class;
  logic [VOTE_W-1:0] vote_count;

  // sideband that travels with a directed beat carrying a typed-in result
  logic row_typed;
  outcome_t row_exp;

  knn_vote_classifier_top i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .mode(cmd_mode),
    .real_part(real_part), .imag_part(imag_part), .class_label(class_label),
    .last_element(last_element), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_data(cfg_data), .done(done), .predicted_class(predicted_class),
    .rejected(rejected), .vote_count(vote_count), .table_empty(table_empty)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // ---------------- predictor state ----------------
  int       ref_re [REFS*VLEN];
  int       ref_im [REFS*VLEN];
  int       ref_cls [REFS];
  int       stored_refs, load_pos, query_pos;
  longint   ref_dist [REFS];
  int       k_reg;
  outcome_t vote_q[$];
  int       error_count;
  int       idle_cycles;

  // generator's own view of the table, to keep queries on written elements
  int plan_total, plan_pos;
  int plan_len [REFS];
  int sent_items;

  function automatic longint sq_diff(int a, int b);
    longint d;
    d = (a >= b) ? longint'(a - b) : longint'(b - a);
    return d * d;
  endfunction

  function automatic longint acc_add(longint a, longint b);
    longint lim;
    lim = (longint'(1) << ACC_W) - 1;
    if (a >= lim || b > lim - a) return lim;
    return a + b;
  endfunction

  // k nearest references vote; ties go to the lower slot and the lower class
  function automatic outcome_t vote_outcome();
    outcome_t o;
    int k, m, best, best_cls, best_votes;
    int votes [CLASS_COUNT];
    int nearest [3];
    bit taken [REFS];
    bit found, disagree;
    o = '0;
    if (stored_refs == 0) return EMPTY_OUT;
    k = k_reg;
    if (k < 1) k = 1;
    if (k > stored_refs) k = stored_refs;
    m = (k < 3) ? 3 : k;
    if (m > stored_refs) m = stored_refs;
    foreach (votes[c]) votes[c] = 0;
    foreach (taken[r]) taken[r] = 0;
    nearest = '{0, 0, 0};
    for (int p = 0; p < m; p++) begin
      best = 0;
      found = 0;
      for (int r = 0; r < stored_refs; r++) begin
        if (!taken[r] && (!found || ref_dist[r] < ref_dist[best])) begin
          best = r;
          found = 1;
        end
      end
      taken[best] = 1;
      if (p < 3) nearest[p] = ref_cls[best];
      if (p < k) votes[ref_cls[best]]++;
    end
    best_cls = 0;
    best_votes = 0;
    for (int c = 0; c < CLASS_COUNT; c++) begin
      if (votes[c] > best_votes) begin
        best_votes = votes[c];
        best_cls = c;
      end
    end
    disagree = (stored_refs < 3) || nearest[0] != nearest[1] || nearest[1] != nearest[2];
    o.cls = CLS_W'(best_cls);
    o.rej = (REJ_VOTE_MUL * best_votes <= REJ_K_MUL * k) && disagree;
    o.votes = VOTE_W'(best_votes);
    o.empty = 1'b0;
    return o;
  endfunction

  // apply one accepted beat; returns 1 when it produces a classification
  function automatic bit apply_beat(mode_t m, int re, int im, int lab, bit last,
                                    output outcome_t o);
    int a;
    o = '0;
    case (m)
      MODE_LOAD: begin
        if (stored_refs < REFS) begin
          if (load_pos < VLEN) begin
            a = stored_refs * VLEN + load_pos;
            ref_re[a] = re;
            ref_im[a] = im;
            load_pos++;
          end
          if (last) begin
            ref_cls[stored_refs] = (lab >= CLASS_COUNT) ? CLASS_COUNT - 1 : lab;
            stored_refs++;
            load_pos = 0;
          end
        end
      end
      MODE_QUERY: begin
        if (query_pos == 0) foreach (ref_dist[r]) ref_dist[r] = 0;
        if (query_pos < VLEN) begin
          for (int r = 0; r < stored_refs; r++) begin
            a = r * VLEN + query_pos;
            ref_dist[r] = acc_add(ref_dist[r], acc_add(sq_diff(ref_re[a], re),
                                                       sq_diff(ref_im[a], im)));
          end
          query_pos++;
        end
        if (last) begin
          query_pos = 0;
          o = vote_outcome();
          return 1;
        end
      end
      MODE_CLEAR: begin
        stored_refs = 0;
        load_pos = 0;
      end
      default: ;
    endcase
    return 0;
  endfunction

  task automatic report_mismatch(string field, int got, int want);
    $display("MISMATCH %s: got %0d expected %0d at %0t", field, got, want, $realtime);
    error_count++;
  endtask

  // ---------------- monitor: predict on accept, check on done ----------------
  always @(posedge clk) begin
    outcome_t o, want;
    if (rst) begin
      stored_refs = 0;
      load_pos = 0;
      query_pos = 0;
      k_reg = int'(K_RESET);
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (done) begin
        idle_cycles = 0;
        if (vote_q.size() == 0) begin
          report_mismatch("unexpected result", 1, 0);
        end else begin
          want = vote_q.pop_front();
          if (predicted_class !== want.cls)
            report_mismatch("predicted_class", predicted_class, want.cls);
          if (rejected !== want.rej) report_mismatch("rejected", rejected, want.rej);
          if (vote_count !== want.votes) report_mismatch("vote_count", vote_count, want.votes);
          if (table_empty !== want.empty)
            report_mismatch("table_empty", table_empty, want.empty);
        end
      end
      if (cfg_valid && cfg_ready) begin
        idle_cycles = 0;
        k_reg = int'(cfg_data);
      end
      if (start && !busy) begin
        idle_cycles = 0;
        if (apply_beat(cmd_mode, real_part, imag_part, class_label, last_element, o))
          vote_q = {vote_q, (row_typed ? row_exp : o)};
      end
      if (idle_cycles >= WD_LIMIT) begin
        $display("Timeout: nothing accepted for %0d cycles", WD_LIMIT);
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // ---------------- driver ----------------
  task automatic send_beat(mode_t m, logic [SAMPLE_BITS-1:0] re, logic [SAMPLE_BITS-1:0] im,
                           logic [CLS_W-1:0] lab, logic last,
                           logic typed = 1'b0, outcome_t ex = NO_OUT);
    if (sent_items < CALM_FROM && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    start <= 1'b1;
    cmd_mode <= m;
    real_part <= re;
    imag_part <= im;
    class_label <= lab;
    last_element <= last;
    row_typed <= typed;
    row_exp <= ex;
    do @(posedge clk); while (busy);
    // track which store elements have been written
    case (m)
      MODE_LOAD: begin
        if (plan_total < REFS) begin
          if (plan_pos < VLEN) begin
            if (plan_len[plan_total] < plan_pos + 1) plan_len[plan_total] = plan_pos + 1;
            plan_pos++;
          end
          if (last) begin
            plan_total++;
            plan_pos = 0;
          end
        end
      end
      MODE_CLEAR: begin
        plan_total = 0;
        plan_pos = 0;
      end
      default: ;
    endcase
    if (m != MODE_NONE) sent_items++;
  endtask

  // beat whose payload fields the block ignores
  task automatic send_noise(mode_t m);
    send_beat(m, SAMPLE_BITS'($urandom), SAMPLE_BITS'($urandom), CLS_W'($urandom),
              1'($urandom));
  endtask

  // write k once the block has drained
  task automatic write_k(int value);
    start <= 1'b0;
    @(posedge clk);
    while (vote_q.size() != 0 || busy) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= VOTE_W'(value);
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // longest query that reads only written elements of every stored slot
  function automatic int query_room();
    int lim;
    if (plan_total == 0) return 3;
    lim = VLEN;
    for (int r = 0; r < plan_total; r++) if (plan_len[r] < lim) lim = plan_len[r];
    return (lim == VLEN) ? VLEN + 3 : lim;
  endfunction

  function automatic logic [SAMPLE_BITS-1:0] pick_sample(int center);
    case ($urandom_range(0, 9))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return SAMPLE_BITS'($urandom);
      default: return SAMPLE_BITS'(center + $urandom_range(0, 1200) - 600);
    endcase
  endfunction

  function automatic int class_center(int c);
    return c * 3800 - 28000;
  endfunction

  task automatic load_vector(int lab, int len, bit close);
    for (int e = 0; e < len; e++)
      send_beat(MODE_LOAD, pick_sample(class_center(lab)), pick_sample(-class_center(lab)),
                CLS_W'(lab), close && e == len - 1);
  endtask

  task automatic query_vector(int len, int near_cls);
    for (int e = 0; e < len; e++) begin
      if ($urandom_range(0, 15) == 0) send_noise(MODE_NONE);
      send_beat(MODE_QUERY, pick_sample(class_center(near_cls)),
                pick_sample(-class_center(near_cls)), CLS_W'($urandom), e == len - 1);
    end
  endtask

  // directed rows: empty table, extremes, ignored mode, clear, clamping of k
  row_t dir_rows [0:19] = '{
    '{MODE_QUERY, 16'h0000, 16'h0000, 4'd0,  1'b1, 1'b1, EMPTY_OUT},
    '{MODE_NONE,  16'h7fff, 16'h8000, 4'd15, 1'b1, 1'b0, NO_OUT},
    '{MODE_LOAD,  16'h8000, 16'h8000, 4'd0,  1'b0, 1'b0, NO_OUT},
    '{MODE_LOAD,  16'h7fff, 16'h7fff, 4'd0,  1'b1, 1'b0, NO_OUT},
    '{MODE_LOAD,  16'h7fff, 16'h8000, 4'd0,  1'b0, 1'b0, NO_OUT},
    '{MODE_LOAD,  16'h0000, 16'h0000, 4'd15, 1'b1, 1'b0, NO_OUT},
    '{MODE_LOAD,  16'h0001, 16'hffff, 4'd0,  1'b0, 1'b0, NO_OUT},
    '{MODE_LOAD,  16'h0000, 16'h0000, 4'd1,  1'b1, 1'b0, NO_OUT},
    '{MODE_QUERY, 16'h8000, 16'h8000, 4'd0,  1'b0, 1'b0, NO_OUT},
    '{MODE_QUERY, 16'h7fff, 16'h7fff, 4'd0,  1'b1, 1'b0, NO_OUT},
    '{MODE_QUERY, 16'h7fff, 16'h8000, 4'd0,  1'b0, 1'b0, NO_OUT},
    '{MODE_QUERY, 16'h0000, 16'h0000, 4'd0,  1'b1, 1'b0, NO_OUT},
    '{MODE_LOAD,  16'h8000, 16'h7fff, 4'd3,  1'b0, 1'b0, NO_OUT},
    '{MODE_CLEAR, 16'h0000, 16'h0000, 4'd0,  1'b0, 1'b0, NO_OUT},
    '{MODE_QUERY, 16'hffff, 16'hffff, 4'd0,  1'b1, 1'b1, EMPTY_OUT},
    '{MODE_LOAD,  16'h1234, 16'h8000, 4'd15, 1'b1, 1'b0, NO_OUT},
    '{MODE_QUERY, 16'h1234, 16'h8000, 4'd0,  1'b1, 1'b0, NO_OUT},
    '{MODE_LOAD,  16'h8000, 16'h8000, 4'd5,  1'b1, 1'b0, NO_OUT},
    '{MODE_LOAD,  16'h8000, 16'h8000, 4'd5,  1'b1, 1'b0, NO_OUT},
    '{MODE_QUERY, 16'h8000, 16'h8000, 4'd0,  1'b1, 1'b0, NO_OUT}
  };

  int k_choices [] = '{0, 1, 2, 3, 4, 5, 7, 10, 64, 127};

  // ---------------- stimulus ----------------
  initial begin
    int ph, nrefs, rlen, ncls, nq, qmax;
    rst = 1'b1;
    start = 1'b0;
    cmd_mode = MODE_NONE;
    real_part = '0;
    imag_part = '0;
    class_label = '0;
    last_element = 1'b0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    row_typed = 1'b0;
    row_exp = NO_OUT;
    error_count = 0;
    plan_total = 0;
    plan_pos = 0;
    sent_items = 0;
    foreach (plan_len[r]) plan_len[r] = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i])
      send_beat(dir_rows[i].m, dir_rows[i].re, dir_rows[i].im, dir_rows[i].lab,
                dir_rows[i].last, dir_rows[i].typed, dir_rows[i].ex);

    ph = 0;
    while (sent_items < ITEMS) begin
      case (ph)
        0: begin
          // fill the table with short vectors; extra loads are dropped
          write_k(64);
          send_noise(MODE_CLEAR);
          for (int r = 0; r < REFS + 6; r++) load_vector($urandom_range(0, 3), 1, 1);
          for (int q = 0; q < 3; q++) query_vector(1, $urandom_range(0, 3));
        end
        1: begin
          // vectors past the element limit; positions saturate
          write_k(127);
          send_noise(MODE_CLEAR);
          for (int r = 0; r < 3; r++) load_vector($urandom_range(0, 15), VLEN + 2, 1);
          for (int q = 0; q < 2; q++) query_vector(query_room(), $urandom_range(0, 15));
        end
        default: begin
          write_k(ph < 2 + k_choices.size() ? k_choices[ph - 2]
                                             : ($urandom_range(0, 4) == 0 ? $urandom_range(0, 127)
                                             : k_choices[$urandom_range(0, k_choices.size() - 1)]));
          if ($urandom_range(0, 1)) send_noise(MODE_CLEAR);
          nrefs = $urandom_range(1, 12);
          rlen = $urandom_range(1, 8);
          ncls = ($urandom_range(0, 3) == 0) ? 16 : $urandom_range(1, 4);
          for (int r = 0; r < nrefs; r++) load_vector($urandom_range(0, ncls - 1), rlen, 1);
          // broken sequence: an unfinished reference, sometimes cleared away
          if ($urandom_range(0, 4) == 0) begin
            load_vector($urandom_range(0, 15), $urandom_range(1, 3), 0);
            if ($urandom_range(0, 1)) send_noise(MODE_CLEAR);
          end
          nq = $urandom_range(2, 6);
          for (int q = 0; q < nq; q++) begin
            qmax = query_room();
            query_vector($urandom_range(1, qmax), $urandom_range(0, ncls - 1));
          end
        end
      endcase
      ph++;
    end
    start <= 1'b0;

    // drain every pending result, then a short settle
    @(posedge clk);
    while (vote_q.size() != 0 || busy) @(posedge clk);
    repeat (500) @(posedge clk);
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/knn_pkg.sv
rtl/core/knn_sq_unit.sv
rtl/core/knn_vote_classifier_top.sv
tb/knn_vote_classifier_top_test.sv
